// ===== hw/rtl/wbpfb_pkg.sv =====
`default_nettype none

package wbpfb_pkg;

  localparam int NETWORKS   = 8;
  localparam int SSID_BYTES = 32;

  localparam int SsidWords = (SSID_BYTES + 3) / 4;
  localparam int NetW      = (NETWORKS > 1) ? $clog2(NETWORKS) : 1;
  localparam int WordW     = (SsidWords > 1) ? $clog2(SsidWords) : 1;
  localparam int SAddrW    = NetW + WordW;
  localparam int LenW      = 6;
  localparam int SeqW      = 12;
  localparam int FrameLenW = 7;
  localparam int WordCntW  = 5;
  localparam int HdrBytes  = 38;
  localparam int BeaconTail = 25;
  localparam int ProbeTail  = 19;
  localparam int MinRoom    = 128;

  localparam logic [47:0] BaseMacRst = 48'h24EC4A010203;
  localparam logic [7:0]  ChanRst    = 8'h01;
  localparam logic [7:0]  FcBeacon   = 8'h80;
  localparam logic [7:0]  FcProbe    = 8'h50;
  localparam logic [7:0]  BssidMul   = 8'h13;

  typedef enum logic [1:0] {
    KIND_SSID_BYTE = 2'd0,
    KIND_SSID_LEN  = 2'd1,
    KIND_BEACON    = 2'd2,
    KIND_PROBE     = 2'd3
  } kind_e;

  typedef enum logic [0:0] {
    CFG_BASE_MAC      = 1'b0,
    CFG_RADIO_CHANNEL = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_META,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  net_index;
    logic [4:0]  ssid_position;
    logic [7:0]  ssid_byte;
    logic [5:0]  ssid_length;
    logic [47:0] peer_mac;
    logic [63:0] timestamp_us;
    logic [15:0] buffer_room;
  } req_t;

  typedef struct packed {
    logic [31:0] frame_word;
    logic [2:0]  byte_count;
    logic        last;
    logic        error;
  } res_t;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic [SeqW-1:0] seq;
  } meta_t;

  // first transmitted octet ends up in the low byte
  function automatic logic [47:0] mac_rev(input logic [47:0] m);
    return {m[7:0], m[15:8], m[23:16], m[31:24], m[39:32], m[47:40]};
  endfunction

  // rates, ds parameter set, tim (beacon only), extended rates
  function automatic logic [7:0] tail_byte(input logic beacon, input logic [4:0] t,
                                           input logic [7:0] chan);
    logic [4:0] idx;
    logic [7:0] b;
    idx = (!beacon && t >= 5'd13) ? 5'(t + 5'd6) : t;
    case (idx)
      5'd0:  b = 8'h01;
      5'd1:  b = 8'h08;
      5'd2:  b = 8'h82;
      5'd3:  b = 8'h84;
      5'd4:  b = 8'h8B;
      5'd5:  b = 8'h96;
      5'd6:  b = 8'h0C;
      5'd7:  b = 8'h12;
      5'd8:  b = 8'h18;
      5'd9:  b = 8'h24;
      5'd10: b = 8'h03;
      5'd11: b = 8'h01;
      5'd12: b = chan;
      5'd13: b = 8'h05;
      5'd14: b = 8'h04;
      5'd15: b = 8'h00;
      5'd16: b = 8'h01;
      5'd17: b = 8'h00;
      5'd18: b = 8'h00;
      5'd19: b = 8'h32;
      5'd20: b = 8'h04;
      5'd21: b = 8'h30;
      5'd22: b = 8'h48;
      5'd23: b = 8'h60;
      5'd24: b = 8'h6C;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wlan_beacon_probe_frame_builder_unit.sv =====
`default_nettype none

// channel       | direction | handshake                       | payload
// request       | in        | start_i, busy_o                 | req_i (req_t)
// result        | out       | result_valid_o (one-cycle strobe) | result_o (res_t)
// configuration | in        | cfg_we_i, cfg_index_i           | cfg_wdata_i
//
// ssid byte and ssid length transactions return nothing
// a frame (57 to 95 bytes) passes through one metadata read/write-back state,
// ST_META, and is then sent as 4-byte output words
// error transactions give their result in the next cycle
// ssid and metadata memories read as zero until written, no clearing pass
// results cannot be stalled; each stays on the ports for one cycle

module wlan_beacon_probe_frame_builder_unit import wbpfb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  req_t        req_i,
  output logic        result_valid_o,
  output res_t        result_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [47:0] cfg_wdata_i
);

  state_e state_q, state_d;

  logic [47:0] base_mac_q;
  logic [7:0]  chan_q;

  logic [31:0] ssid_mem [NETWORKS*SsidWords];
  logic [NETWORKS*SsidWords-1:0] ssid_vld_q;
  logic [31:0] ssid_rdata_q;
  logic        ssid_rvld_q;
  logic [31:0] ssid_word;
  logic [31:0] ssid_prev_q;
  logic [SAddrW-1:0] ssid_waddr, ssid_raddr;
  logic        ssid_we;

  meta_t       meta_mem [NETWORKS];
  logic [NETWORKS-1:0] meta_vld_q;
  meta_t       meta_rd_q, meta_cur, meta_wdata;
  logic        meta_rvld_q;
  logic        meta_we;
  logic [NetW-1:0] meta_waddr;

  logic            accept, net_ok, len_we, frame_req, err_req, frame_go;
  logic [NetW-1:0] net_a;
  logic [LenW-1:0] len_sat;

  logic [NetW-1:0]      net_q;
  logic                 beacon_q;
  logic [47:0]          client_q;
  logic [63:0]          ts_q;
  logic [LenW-1:0]      len_q;
  logic [SeqW-1:0]      seq_q;
  logic [FrameLenW-1:0] flen_q;
  logic [WordCntW-1:0]  k_q, k_d;

  logic [47:0]          bssid, dest;
  logic [7:0]           bssid_x;
  logic [HdrBytes*8-1:0] hdr;
  logic [31:0]          ssid_win;
  logic [FrameLenW-1:0] ssid_end, rem;
  logic [31:0]          word_d;
  logic [2:0]           cnt_d;
  logic                 last_d;

  logic res_valid_q, res_valid_d;
  res_t res_q, res_d;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_mac_q <= BaseMacRst;
      chan_q     <= ChanRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_BASE_MAC:      base_mac_q <= cfg_wdata_i;
        CFG_RADIO_CHANNEL: chan_q     <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // request decode
  assign accept    = start_i && !busy_o;
  assign net_ok    = 32'(req_i.net_index) < NETWORKS;
  assign net_a     = NetW'(req_i.net_index);
  assign ssid_we   = accept && net_ok && (req_i.kind == KIND_SSID_BYTE) &&
                     (32'(req_i.ssid_position) < SSID_BYTES);
  assign len_we    = accept && net_ok && (req_i.kind == KIND_SSID_LEN);
  assign frame_req = accept && net_ok &&
                     ((req_i.kind == KIND_BEACON) || (req_i.kind == KIND_PROBE));
  assign err_req   = frame_req && (32'(req_i.buffer_room) < MinRoom);
  assign frame_go  = frame_req && !err_req;
  assign len_sat   = (32'(req_i.ssid_length) > SSID_BYTES) ? LenW'(SSID_BYTES)
                                                           : req_i.ssid_length;

  // ssid memory, word wide with byte writes
  assign ssid_waddr = {net_a, WordW'(req_i.ssid_position >> 2)};
  assign ssid_raddr = {net_q, WordW'(k_q - WordCntW'(8))};

  always_ff @(posedge clk_i) begin
    if (ssid_we) begin
      if (ssid_vld_q[ssid_waddr]) begin
        ssid_mem[ssid_waddr][8*req_i.ssid_position[1:0] +: 8] <= req_i.ssid_byte;
      end else begin
        ssid_mem[ssid_waddr] <= {24'h0, req_i.ssid_byte} << {req_i.ssid_position[1:0], 3'b000};
      end
    end
    ssid_rdata_q <= ssid_mem[ssid_raddr];
    ssid_prev_q  <= ssid_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ssid_vld_q  <= '0;
      ssid_rvld_q <= 1'b0;
    end else begin
      if (ssid_we) begin
        ssid_vld_q[ssid_waddr] <= 1'b1;
      end
      ssid_rvld_q <= ssid_vld_q[ssid_raddr];
    end
  end

  assign ssid_word = ssid_rvld_q ? ssid_rdata_q : 32'h0;

  // per network metadata ram: read at accept, written by ssid length and ST_META
  assign meta_we    = len_we || (state_q == ST_META);
  assign meta_waddr = len_we ? net_a : net_q;
  assign meta_cur   = meta_rvld_q ? meta_rd_q : '0;
  always_comb begin
    meta_wdata = '0;
    if (len_we) begin
      meta_wdata.len = len_sat;
    end else begin
      meta_wdata.len = meta_cur.len;
      meta_wdata.seq = SeqW'(meta_cur.seq + SeqW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (frame_go) begin
      meta_rd_q <= meta_mem[net_a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_vld_q  <= '0;
      meta_rvld_q <= 1'b0;
    end else begin
      if (meta_we) begin
        meta_vld_q[meta_waddr] <= 1'b1;
      end
      if (frame_go) begin
        meta_rvld_q <= meta_vld_q[net_a];
      end
    end
  end

  // frame context
  always_ff @(posedge clk_i) begin
    if (frame_go) begin
      net_q    <= net_a;
      beacon_q <= (req_i.kind == KIND_BEACON);
      client_q <= req_i.peer_mac;
      ts_q     <= req_i.timestamp_us;
    end
    if (state_q == ST_META) begin
      len_q  <= meta_cur.len;
      seq_q  <= meta_cur.seq;
      flen_q <= FrameLenW'(HdrBytes) + FrameLenW'(meta_cur.len) +
                (beacon_q ? FrameLenW'(BeaconTail) : FrameLenW'(ProbeTail));
    end
  end

  // header bytes, byte 0 in the low bits
  assign bssid_x = 8'((32'(net_q) + 32'd1) * 32'(BssidMul));
  assign bssid   = {(base_mac_q[47:40] | 8'h02) & 8'hFE, base_mac_q[39:8],
                    base_mac_q[7:0] ^ bssid_x};
  assign dest    = beacon_q ? 48'hFFFF_FFFF_FFFF : client_q;
  assign hdr     = {{2'b00, len_q}, 8'h00, 8'h04, 8'h21, 8'h00, 8'h64, ts_q,
                    seq_q[11:4], {seq_q[3:0], 4'h0}, mac_rev(bssid), mac_rev(bssid),
                    mac_rev(dest), 24'h0, beacon_q ? FcBeacon : FcProbe};

  // ssid bytes start at frame byte 38, so lanes 0-1 take the upper half of the
  // previous word and lanes 2-3 the lower half of the current one
  assign ssid_win = {ssid_word[15:0], ssid_prev_q[31:16]};
  assign ssid_end = FrameLenW'(HdrBytes) + FrameLenW'(len_q);
  assign rem      = flen_q - {k_q, 2'b00};

  always_comb begin
    logic [FrameLenW-1:0] p;
    logic [5:0]           hp;
    word_d = 32'h0;
    for (int i = 0; i < 4; i++) begin
      p  = {k_q, 2'b00} + FrameLenW'(i);
      hp = (p < FrameLenW'(HdrBytes)) ? p[5:0] : 6'd0;
      if (p < FrameLenW'(HdrBytes)) begin
        word_d[8*i +: 8] = hdr[8*hp +: 8];
      end else if (p < ssid_end) begin
        word_d[8*i +: 8] = ssid_win[8*i +: 8];
      end else if (p < flen_q) begin
        word_d[8*i +: 8] = tail_byte(beacon_q, 5'(p - ssid_end), chan_q);
      end
    end
  end

  assign cnt_d  = (rem >= FrameLenW'(4)) ? 3'd4 : rem[2:0];
  assign last_d = (rem <= FrameLenW'(4));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (frame_go) state_d = ST_META;
      ST_META: state_d = ST_EMIT;
      ST_EMIT: if (last_d) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy_o      = (state_q != ST_IDLE);
    k_d         = k_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    case (state_q)
      ST_IDLE: begin
        if (err_req) begin
          res_valid_d = 1'b1;
          res_d.last  = 1'b1;
          res_d.error = 1'b1;
        end
      end
      ST_META: k_d = '0;
      ST_EMIT: begin
        k_d              = WordCntW'(k_q + WordCntW'(1));
        res_valid_d      = 1'b1;
        res_d.frame_word = word_d;
        res_d.byte_count = cnt_d;
        res_d.last       = last_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.error |-> result_o.last && (result_o.byte_count == 3'd0))
    else $error("error result not a lone last result");

  a_full_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> (result_o.byte_count == 3'd4))
    else $error("partial word before end of frame");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && ((req_i.kind == KIND_BEACON) || (req_i.kind == KIND_PROBE)) &&
    (req_i.buffer_room >= 16'(MinRoom)) |=> (state_q == ST_META))
    else $error("frame transaction not started");

  a_meta_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_META) |=> (state_q == ST_EMIT) && (k_q == '0))
    else $error("metadata cycle not followed by output");

endmodule

`default_nettype wire
